FILE: rtl/core/vrd_pkg.sv
`timescale 1ns / 1ps
package vrd_pkg;

    // frame geometry
    localparam int HEIGHT = 480;
    localparam int WIDTH  = 640;

    localparam int ROW_W   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam int COL_W   = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    // frame store address: {bank, row, column}
    localparam int FA_W    = 1 + ROW_W + COL_W;
    // row mark address: {bank, row}
    localparam int MA_W    = 1 + ROW_W;
    // frame tag kept per row mark, zero is reserved for cleared marks
    localparam int EPOCH_W = 16;

    // sync pair
    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    // payload byte write into the frame store
    typedef struct packed {
        logic            en;
        logic [FA_W-1:0] addr;
        logic [7:0]      data;
    } t_pix_wr;

    // row mark write
    typedef struct packed {
        logic               en;
        logic [MA_W-1:0]    addr;
        logic [EPOCH_W-1:0] tag;
    } t_mark_wr;

    // per-transaction status from the parser
    typedef struct packed {
        logic done;
        logic dropped;
        logic any;
    } t_flags;

endpackage

FILE: rtl/core/vrd_frame_mem.sv
`timescale 1ns / 1ps
module vrd_frame_mem (
    input  logic                i_clk,
    input  vrd_pkg::t_pix_wr    i_wr,
    input  logic                i_rd_en,
    input  logic [vrd_pkg::FA_W-1:0] i_rd_addr,
    output logic [7:0]          o_rd_data
);
    import vrd_pkg::*;

    logic [7:0] r_mem [2**FA_W];
    logic [7:0] r_rd_data;

    // payload write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/vrd_mark_mem.sv
`timescale 1ns / 1ps
module vrd_mark_mem (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  vrd_pkg::t_mark_wr        i_wr,
    input  logic                     i_rd_en,
    input  logic [vrd_pkg::MA_W-1:0] i_rd_addr,
    output logic [vrd_pkg::EPOCH_W-1:0] o_rd_tag,
    output logic                     o_busy
);
    import vrd_pkg::*;

    logic [EPOCH_W-1:0] r_mem [2**MA_W];
    logic [EPOCH_W-1:0] r_rd_tag;
    logic               r_clr_active;
    logic [MA_W-1:0]    r_clr_addr;

    logic               wr_en;
    logic [MA_W-1:0]    wr_addr;
    logic [EPOCH_W-1:0] wr_tag;

    // clearing sweep after reset owns the write port
    always_comb begin
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_tag  = '0;
        end else begin
            wr_en   = i_wr.en;
            wr_addr = i_wr.addr;
            wr_tag  = i_wr.tag;
        end
    end

    // sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // tag write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_tag;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_tag <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_tag = r_rd_tag;
    assign o_busy   = r_clr_active;

endmodule

FILE: rtl/core/vrd_parser.sv
`timescale 1ns / 1ps
module vrd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [7:0]                  i_byte,
    output vrd_pkg::t_pix_wr            o_pix_wr,
    output vrd_pkg::t_mark_wr           o_mark_wr,
    output vrd_pkg::t_flags             o_flags,
    output logic                        o_done_bank,
    output logic [vrd_pkg::EPOCH_W-1:0] o_done_epoch
);
    import vrd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_ROW_HI = 3'd2,
        PH_ROW_LO = 3'd3,
        PH_DATA   = 3'd4
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [7:0]         r_row_hi, n_row_hi;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic               r_bank, n_bank;
    logic               r_any, n_any;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [EPOCH_W-1:0] r_done_epoch, n_done_epoch;

    logic [15:0]        row_full;
    logic [EPOCH_W-1:0] epoch_inc;

    assign row_full  = {r_row_hi, i_byte};
    assign epoch_inc = r_epoch + 1'b1;

    // next state of the byte parser
    always_comb begin
        n_phase      = r_phase;
        n_row_hi     = r_row_hi;
        n_row        = r_row;
        n_col        = r_col;
        n_bank       = r_bank;
        n_any        = r_any;
        n_epoch      = r_epoch;
        n_done_epoch = r_done_epoch;
        o_pix_wr     = '0;
        o_mark_wr    = '0;
        o_flags      = '0;
        if (i_en) begin
            case (r_phase)
                PH_SYNC2: begin
                    n_phase = (i_byte == SYNC_SECOND) ? PH_ROW_HI : PH_HUNT;
                end
                PH_ROW_HI: begin
                    n_row_hi = i_byte;
                    n_phase  = PH_ROW_LO;
                end
                PH_ROW_LO: begin
                    if (32'(row_full) >= 32'(HEIGHT)) begin
                        o_flags.dropped = 1'b1;
                        n_phase         = PH_HUNT;
                    end else begin
                        // mark the row with the tag of the current frame
                        o_mark_wr.en   = 1'b1;
                        o_mark_wr.addr = {r_bank, ROW_W'(row_full)};
                        o_mark_wr.tag  = r_epoch;
                        n_row          = ROW_W'(row_full);
                        n_col          = '0;
                        n_phase        = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_pix_wr.en   = 1'b1;
                    o_pix_wr.addr = {r_bank, r_row, r_col};
                    o_pix_wr.data = i_byte;
                    if (r_col == COL_W'(WIDTH - 1)) begin
                        n_col   = '0;
                        n_phase = PH_HUNT;
                        // last row ends the frame: swap banks, new tag makes old marks stale
                        if (r_row == ROW_W'(HEIGHT - 1)) begin
                            n_bank       = ~r_bank;
                            n_done_epoch = r_epoch;
                            n_epoch      = (epoch_inc == '0) ? EPOCH_W'(1) : epoch_inc;
                            n_any        = 1'b1;
                            o_flags.done = 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                default: begin
                    n_phase = (i_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
        o_flags.any = n_any;
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_row        <= '0;
            r_col        <= '0;
            r_bank       <= 1'b0;
            r_any        <= 1'b0;
            r_epoch      <= EPOCH_W'(1);
            r_done_epoch <= EPOCH_W'(1);
        end else begin
            r_phase      <= n_phase;
            r_row        <= n_row;
            r_col        <= n_col;
            r_bank       <= n_bank;
            r_any        <= n_any;
            r_epoch      <= n_epoch;
            r_done_epoch <= n_done_epoch;
        end
    end

    // row high byte, payload only
    always_ff @(posedge i_clk) begin
        r_row_hi <= n_row_hi;
    end

    assign o_done_bank  = ~r_bank;
    assign o_done_epoch = r_done_epoch;

endmodule

FILE: rtl/core/video_row_deframer.sv
`timescale 1ns / 1ps
// pipeline: a result passes the memory read register and then the output register
// throughput: one transaction per cycle, stream bytes and reads alike, while i_m_tready
//   allows; set by the single write and read port of the frame store and row mark memory
// reset: i_rst_n synchronous, active low; afterwards the row marks are swept to zero,
//   2 * 2**clog2(HEIGHT) marks (1024 at 480 rows), with o_s_tready low during the sweep
module video_row_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // data_byte[7:0], read_row[16:8], read_column[26:17], zero[31:27]
    input  logic [31:0] i_s_tdata,
    // op[0]
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // frame_done[0], row_dropped[1], pixel_value[9:2], frame_ready[10], zero[15:11]
    output logic [15:0] o_m_tdata
);
    import vrd_pkg::*;

    logic               accept;
    logic               out_free;
    logic               busy;
    logic               stream_en;
    logic               read_en;
    logic               rd_in_range;
    logic [7:0]         in_byte;
    logic [8:0]         in_row;
    logic [9:0]         in_col;

    t_pix_wr            pix_wr;
    t_mark_wr           mark_wr;
    t_flags             flags;
    logic               done_bank;
    logic [EPOCH_W-1:0] done_epoch;
    logic [7:0]         pix_data;
    logic [EPOCH_W-1:0] mark_tag;

    logic               r_s1_valid;
    logic               r_s1_rd_ok;
    t_flags             r_s1_flags;
    logic [EPOCH_W-1:0] r_s1_epoch;
    logic               r_out_valid;
    logic [15:0]        r_out_data;
    logic [7:0]         s1_pixel;

    // input unpacking
    assign in_byte = i_s_tdata[7:0];
    assign in_row  = i_s_tdata[16:8];
    assign in_col  = i_s_tdata[26:17];

    // handshake and pipeline advance
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !busy && (!r_s1_valid || out_free);
    assign accept     = i_s_tvalid && o_s_tready;
    assign stream_en  = accept && !i_s_tuser;
    assign read_en    = accept && i_s_tuser;
    assign rd_in_range = (32'(in_row) < 32'(HEIGHT)) && (32'(in_col) < 32'(WIDTH));

    vrd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (stream_en),
        .i_byte       (in_byte),
        .o_pix_wr     (pix_wr),
        .o_mark_wr    (mark_wr),
        .o_flags      (flags),
        .o_done_bank  (done_bank),
        .o_done_epoch (done_epoch)
    );

    vrd_frame_mem u_frame_mem (
        .i_clk     (i_clk),
        .i_wr      (pix_wr),
        .i_rd_en   (read_en),
        .i_rd_addr ({done_bank, ROW_W'(in_row), COL_W'(in_col)}),
        .o_rd_data (pix_data)
    );

    vrd_mark_mem u_mark_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mark_wr),
        .i_rd_en   (read_en),
        .i_rd_addr ({done_bank, ROW_W'(in_row)}),
        .o_rd_tag  (mark_tag),
        .o_busy    (busy)
    );

    // stage 1: memory data arrives, flags travel alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd_ok <= i_s_tuser && rd_in_range;
            r_s1_flags <= flags;
            r_s1_epoch <= done_epoch;
        end
    end

    // a row counts only if its mark carries the completed frame's tag
    assign s1_pixel = (r_s1_rd_ok && (mark_tag == r_s1_epoch)) ? pix_data : 8'd0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_data <= {5'd0, r_s1_flags.any, s1_pixel,
                           r_s1_flags.dropped, r_s1_flags.done};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
